### hdl/ccu_pkg.sv
// shared constants, codes and control types of the combinatorial count unit
`timescale 1ns / 1ps
package ccu_pkg;

  localparam int MAX_COUNT_N  = 20;
  localparam int NUM_GROUPS   = 5;
  localparam int GROUP_FIELDS = 5;

  localparam int CMD_W    = 3;
  localparam int FIELD_W  = 5;
  localparam int COUNT_W  = 64;
  localparam int STATUS_W = 2;
  localparam int FAC_W    = FIELD_W + 1;
  localparam int GRP_IDX_W = $clog2(GROUP_FIELDS);

  // divider retires this many quotient bits per cycle
  localparam int DIV_BITS   = 8;
  localparam int DIV_CYCLES = COUNT_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam logic [CMD_W-1:0] CMD_ARRANGE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POWER   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_COMB    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MSET    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FACT    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_MULTI   = 3'd5;

  localparam logic [STATUS_W-1:0] STS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STS_KGTN = 2'd1;
  localparam logic [STATUS_W-1:0] STS_OVF  = 2'd2;

  localparam logic [COUNT_W-1:0] ALL_ONES = {COUNT_W{1'b1}};

  localparam logic [FIELD_W-1:0] GROUP_DEFAULT [GROUP_FIELDS] =
    '{5'd1, 5'd1, 5'd1, 5'd1, 5'd1};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_BDIV_START,
    ST_BDIV_WAIT,
    ST_GSEL,
    ST_GDIV_START,
    ST_GDIV_WAIT,
    ST_FINISH
  } ccu_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_start;
    logic div_take;
    logic inc_i;
    logic clr_i;
    logic next_grp;
    logic publish;
  } ccu_cmd_t;

  typedef struct packed {
    logic early;
    logic loop_zero;
    logic loop_last;
    logic binom;
    logic multi;
    logic div_done;
    logic grp_zero;
    logic grp_iter_last;
    logic grp_last;
    logic out_full;
  } ccu_sts_t;

endpackage

### hdl/ccu_div.sv
// multi-cycle divider of a 64-bit word by a small divisor
`timescale 1ns / 1ps
module ccu_div
  import ccu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [COUNT_W-1:0] dividend,
  input  logic [FIELD_W-1:0] divisor,
  output logic               done,
  output logic [COUNT_W-1:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]   q_r, q_nxt;
  logic [FIELD_W-1:0]   rem_r, rem_nxt;
  logic [FIELD_W-1:0]   d_r, d_nxt;

  // restoring division, several quotient bits per cycle on a narrow remainder
  always_comb begin
    logic [FIELD_W:0]   wide;
    logic [COUNT_W-1:0] q_v;
    logic [FIELD_W-1:0] rem_v;
    q_v   = q_r;
    rem_v = rem_r;
    wide  = '0;
    for (int b = 0; b < DIV_BITS; b++) begin
      wide = {rem_v, q_v[COUNT_W-1]};
      q_v  = {q_v[COUNT_W-2:0], 1'b0};
      if (wide >= {1'b0, d_r}) begin
        wide   = wide - {1'b0, d_r};
        q_v[0] = 1'b1;
      end
      rem_v = wide[FIELD_W-1:0];
    end

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      q_nxt   = q_v;
      rem_nxt = rem_v;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### hdl/ccu_dp.sv
// datapath: operand registers, multiply-accumulate, divider and result register
`timescale 1ns / 1ps
module ccu_dp
  import ccu_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ccu_cmd_t            cmd,
  output ccu_sts_t            sts,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [FIELD_W-1:0]  in_n,
  input  logic [FIELD_W-1:0]  in_k,
  input  logic [FIELD_W-1:0]  in_group_a,
  input  logic [FIELD_W-1:0]  in_group_b,
  input  logic [FIELD_W-1:0]  in_group_c,
  input  logic [FIELD_W-1:0]  in_group_d,
  input  logic [FIELD_W-1:0]  in_group_e,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COUNT_W-1:0]  out_count,
  output logic [STATUS_W-1:0] out_status
);

  logic [CMD_W-1:0]     mode_r, mode_nxt;
  logic [FIELD_W-1:0]   n_r, n_nxt;
  logic [FIELD_W-1:0]   k_r, k_nxt;
  logic [FIELD_W-1:0]   grp_r [GROUP_FIELDS];
  logic [FIELD_W-1:0]   grp_nxt [GROUP_FIELDS];
  logic [COUNT_W-1:0]   acc_r, acc_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [STATUS_W-1:0]  st_r, st_nxt;
  logic                 early_r, early_nxt;
  logic [FIELD_W-1:0]   i_r, i_nxt;
  logic [GRP_IDX_W-1:0] g_r, g_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;

  logic [FIELD_W-1:0]   grp_in [GROUP_FIELDS];
  logic                 range_bad;
  logic                 grp_bad;
  logic [FIELD_W-1:0]   iter_cnt;
  logic [FIELD_W-1:0]   i_inc;
  logic [FAC_W-1:0]     mfac;
  logic [COUNT_W+FAC_W-1:0] prod;
  logic [FIELD_W-1:0]   grp_cur;
  logic                 div_done;
  logic [COUNT_W-1:0]   quotient;

  ccu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (acc_r),
    .divisor  (i_inc),
    .done     (div_done),
    .quotient (quotient)
  );

  // groups past the configured count act as size one
  always_comb begin
    logic [FIELD_W-1:0] raw [GROUP_FIELDS];
    raw[0] = in_group_a;
    raw[1] = in_group_b;
    raw[2] = in_group_c;
    raw[3] = in_group_d;
    raw[4] = in_group_e;
    grp_bad = 1'b0;
    for (int g = 0; g < GROUP_FIELDS; g++) begin
      grp_in[g] = (g < NUM_GROUPS) ? raw[g] : GROUP_DEFAULT[g];
      if (grp_in[g] > FIELD_W'(MAX_COUNT_N)) grp_bad = 1'b1;
    end
  end

  assign range_bad = (in_n > FIELD_W'(MAX_COUNT_N)) ||
                     ((in_cmd <= CMD_MSET) && (in_k > FIELD_W'(MAX_COUNT_N))) ||
                     ((in_cmd == CMD_MULTI) && grp_bad);

  assign i_inc    = i_r + 1'b1;
  assign iter_cnt = ((mode_r == CMD_FACT) || (mode_r == CMD_MULTI)) ? n_r : k_r;
  assign grp_cur  = grp_r[g_r];

  // factor for the current multiply step
  always_comb begin
    case (mode_r)
      CMD_ARRANGE: mfac = {1'b0, n_r} - {1'b0, k_r} + {1'b0, i_r} + FAC_W'(1);
      CMD_POWER:   mfac = {1'b0, n_r};
      CMD_COMB:    mfac = {1'b0, n_r} - {1'b0, i_r};
      CMD_MSET:    mfac = {1'b0, n_r} + {1'b0, k_r} - FAC_W'(1) - {1'b0, i_r};
      CMD_FACT:    mfac = {1'b0, i_inc};
      CMD_MULTI:   mfac = {1'b0, i_inc};
      default:     mfac = FAC_W'(1);
    endcase
  end

  assign prod = (COUNT_W+FAC_W)'(acc_r) * (COUNT_W+FAC_W)'(mfac);

  always_comb begin
    mode_nxt  = mode_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    grp_nxt   = grp_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    st_nxt    = st_r;
    early_nxt = early_r;
    i_nxt     = i_r;
    g_nxt     = g_r;

    if (cmd.load) begin
      mode_nxt = in_cmd;
      n_nxt    = in_n;
      k_nxt    = in_k;
      grp_nxt  = grp_in;
      ovf_nxt  = 1'b0;
      i_nxt    = '0;
      g_nxt    = '0;
      if (in_cmd > CMD_MULTI) begin
        early_nxt = 1'b1;
        acc_nxt   = '0;
        st_nxt    = STS_OK;
      end else if (range_bad) begin
        early_nxt = 1'b1;
        acc_nxt   = ALL_ONES;
        st_nxt    = STS_OVF;
      end else if (((in_cmd == CMD_ARRANGE) || (in_cmd == CMD_COMB)) && (in_k > in_n)) begin
        early_nxt = 1'b1;
        acc_nxt   = '0;
        st_nxt    = STS_KGTN;
      end else begin
        early_nxt = 1'b0;
        acc_nxt   = COUNT_W'(1);
        st_nxt    = STS_OK;
      end
    end else begin
      if (cmd.mul) begin
        acc_nxt = prod[COUNT_W-1:0];
        ovf_nxt = ovf_r | (|prod[COUNT_W+FAC_W-1:COUNT_W]);
      end else if (cmd.div_take) begin
        acc_nxt = quotient;
      end
      if (cmd.clr_i) begin
        i_nxt = '0;
      end else if (cmd.inc_i) begin
        i_nxt = i_inc;
      end
      if (cmd.next_grp) g_nxt = g_r + 1'b1;
    end
  end

  // result register; a stalled word is held here, and the controller waits to publish the next word until it is taken
  always_comb begin
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    if (cmd.publish) begin
      out_valid_nxt  = 1'b1;
      out_count_nxt  = ovf_r ? ALL_ONES : acc_r;
      out_status_nxt = ovf_r ? STS_OVF : st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    n_r          <= n_nxt;
    k_r          <= k_nxt;
    grp_r        <= grp_nxt;
    acc_r        <= acc_nxt;
    ovf_r        <= ovf_nxt;
    st_r         <= st_nxt;
    early_r      <= early_nxt;
    i_r          <= i_nxt;
    g_r          <= g_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    sts.early         = early_r;
    sts.loop_zero     = (iter_cnt == '0);
    sts.loop_last     = (i_inc == iter_cnt);
    sts.binom         = (mode_r == CMD_COMB) || (mode_r == CMD_MSET);
    sts.multi         = (mode_r == CMD_MULTI);
    sts.div_done      = div_done;
    sts.grp_zero      = (grp_cur == '0);
    sts.grp_iter_last = (i_inc == grp_cur);
    sts.grp_last      = (g_r == GRP_IDX_W'(GROUP_FIELDS - 1));
    sts.out_full      = out_valid_r && out_stall;
  end

  assign out_valid  = out_valid_r;
  assign out_count  = out_count_r;
  assign out_status = out_status_r;

endmodule

### hdl/ccu_ctrl.sv
// controller state machine sequencing multiply and divide steps
`timescale 1ns / 1ps
module ccu_ctrl
  import ccu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ccu_sts_t sts,
  output ccu_cmd_t cmd
);

  ccu_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.early) begin
          state_nxt = ST_FINISH;
        end else if (sts.loop_zero) begin
          state_nxt = sts.multi ? ST_GSEL : ST_FINISH;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (sts.binom) begin
          state_nxt = ST_BDIV_START;
        end else begin
          cmd.inc_i = 1'b1;
          if (sts.loop_last) begin
            cmd.clr_i = 1'b1;
            state_nxt = sts.multi ? ST_GSEL : ST_FINISH;
          end
        end
      end
      ST_BDIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_BDIV_WAIT;
      end
      ST_BDIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          cmd.inc_i    = 1'b1;
          state_nxt    = sts.loop_last ? ST_FINISH : ST_MUL;
        end
      end
      // divide by each group factorial one factor at a time
      ST_GSEL: begin
        if (sts.grp_zero) begin
          if (sts.grp_last) begin
            state_nxt = ST_FINISH;
          end else begin
            cmd.next_grp = 1'b1;
          end
        end else begin
          state_nxt = ST_GDIV_START;
        end
      end
      ST_GDIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_GDIV_WAIT;
      end
      ST_GDIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          cmd.inc_i    = 1'b1;
          if (sts.grp_iter_last) begin
            cmd.clr_i = 1'b1;
            if (sts.grp_last) begin
              state_nxt = ST_FINISH;
            end else begin
              cmd.next_grp = 1'b1;
              state_nxt    = ST_GSEL;
            end
          end else begin
            state_nxt = ST_GDIV_START;
          end
        end
      end
      ST_FINISH: begin
        if (!sts.out_full) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/combinatorial_count_unit.sv
// Combinatorial count unit: one request word in, one exact count word out. Requests are
// taken one at a time. After acceptance a request is checked, then takes one multiply
// per factor in the arrangement, power and factorial modes (at most 20 factors); per
// chosen element in the two combination modes a multiply, a divider start and a wait
// on the divide; and for the multinomial, one multiply per factor of n, then per group
// of size g a divider start and a wait on the divide for each of its g factors.
// Error, out-of-range and unused-mode requests go from the check straight to the
// output. The next request is accepted at the earliest in the cycle after the previous
// word is published, and a word still stalled in the output register holds the publish
// of the following one. The 64-bit by 5-bit divider, which retires 8 quotient bits a
// cycle, sets the cost of every divide step. A finished word waits in the output
// register while the next request is accepted.
`timescale 1ns / 1ps
module combinatorial_count_unit
  import ccu_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [FIELD_W-1:0]  in_n,
  input  logic [FIELD_W-1:0]  in_k,
  input  logic [FIELD_W-1:0]  in_group_a,
  input  logic [FIELD_W-1:0]  in_group_b,
  input  logic [FIELD_W-1:0]  in_group_c,
  input  logic [FIELD_W-1:0]  in_group_d,
  input  logic [FIELD_W-1:0]  in_group_e,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COUNT_W-1:0]  out_count,
  output logic [STATUS_W-1:0] out_status
);

  ccu_cmd_t cmd;
  ccu_sts_t sts;

  ccu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ccu_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_cmd     (in_cmd),
    .in_n       (in_n),
    .in_k       (in_k),
    .in_group_a (in_group_a),
    .in_group_b (in_group_b),
    .in_group_c (in_group_c),
    .in_group_d (in_group_d),
    .in_group_e (in_group_e),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_count  (out_count),
    .out_status (out_status)
  );

endmodule
